// ===== rtl/register_frame_codec_top_defines.svh =====
`ifndef REGISTER_FRAME_CODEC_TOP_DEFINES_SVH
`define REGISTER_FRAME_CODEC_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RFC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("register frame codec check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define RFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("register frame codec check failed");

`endif

// ===== rtl/rfc_pkg.sv =====
`default_nettype none

package rfc_pkg;

  localparam logic [7:0]  FRAME_HEADER   = 8'hA5;
  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h00FF;
  localparam logic [2:0]  MAX_DATA_BYTES = 3'd4;
  localparam int unsigned FRAME_BYTES    = 5;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RX      = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_REPLY = 2'd1,
    STATUS_BAD_SUM  = 2'd2
  } status_e;

  typedef enum logic {
    OUT_TX     = 1'b0,
    OUT_REPORT = 1'b1
  } out_kind_e;

  // results caused by one beat: a frame of bytes or a single report
  typedef struct packed {
    out_kind_e                   mode;
    logic [2:0]                  count;
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [31:0]                 value;
    status_e                     status;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/register_frame_codec_top.sv =====
// Output: the first result of a beat is shown in the cycle after it is accepted.
// Throughput: results leave one per cycle from the output frame register while
// out_ready_i is high; a new beat is taken in the cycle the last result of the
// previous one is taken. A write frame has up to 5 results, a read frame 2.
// Reset: rst_ni (async, low) clears the read tracking state and empties the frame.
`default_nettype none

module register_frame_codec_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  reg_addr_i,
  input  wire logic [15:0] write_data_i,
  input  wire logic [2:0]  read_size_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             out_kind_o,
  output logic [7:0]       tx_byte_o,
  output logic             end_of_run_o,
  output logic [31:0]      read_value_o,
  output logic [1:0]       read_status_o
);

  rfc_pkg::frame_t frame;
  logic            fire;

  assign fire = in_valid_i && in_ready_o;

  rfc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .kind_i       (kind_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .read_size_i  (read_size_i),
    .rx_byte_i    (rx_byte_i),
    .frame_o      (frame)
  );

  rfc_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .frame_i       (frame),
    .load_ok_o     (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_kind_o    (out_kind_o),
    .tx_byte_o     (tx_byte_o),
    .end_of_run_o  (end_of_run_o),
    .read_value_o  (read_value_o),
    .read_status_o (read_status_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rfc_engine.sv =====
`default_nettype none

module rfc_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [1:0]      kind_i,
  input  wire logic [7:0]      reg_addr_i,
  input  wire logic [15:0]     write_data_i,
  input  wire logic [2:0]      read_size_i,
  input  wire logic [7:0]      rx_byte_i,
  output rfc_pkg::frame_t      frame_o
);

  logic        pending_q, pending_d;
  logic [7:0]  preg_q, preg_d;
  logic [2:0]  exp_q, exp_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  newest_q, newest_d;

  logic        finish;
  logic [7:0]  hdr_sum;
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [2:0]  size_sat;

  assign hdr_sum  = rfc_pkg::FRAME_HEADER + reg_addr_i;
  assign lo_byte  = write_data_i[7:0];
  assign hi_byte  = write_data_i[15:8];
  assign size_sat = (read_size_i > rfc_pkg::MAX_DATA_BYTES) ? rfc_pkg::MAX_DATA_BYTES
                                                             : read_size_i;

  always_comb begin
    pending_d = pending_q;
    preg_d    = preg_q;
    exp_d     = exp_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    newest_d  = newest_q;
    finish    = 1'b0;
    frame_o   = '0;
    frame_o.mode   = rfc_pkg::OUT_TX;
    frame_o.status = rfc_pkg::STATUS_OK;
    frame_o.bytes[0] = rfc_pkg::FRAME_HEADER;
    frame_o.bytes[1] = reg_addr_i;

    unique case (rfc_pkg::kind_e'(kind_i))
      rfc_pkg::KIND_WRITE: begin
        if (write_data_i == 16'd0) begin
          frame_o.count = 3'd2;
        end else if (write_data_i < rfc_pkg::ONE_BYTE_LIMIT) begin
          frame_o.bytes[2] = lo_byte;
          frame_o.bytes[3] = ~(hdr_sum + lo_byte);
          frame_o.count    = 3'd4;
        end else begin
          frame_o.bytes[2] = hi_byte;
          frame_o.bytes[3] = lo_byte;
          frame_o.bytes[4] = ~(hdr_sum + hi_byte + lo_byte);
          frame_o.count    = 3'd5;
        end
      end
      rfc_pkg::KIND_READ: begin
        frame_o.count = 3'd2;
        pending_d = 1'b1;
        preg_d    = reg_addr_i;
        exp_d     = size_sat;
        cnt_d     = 3'd0;
        acc_d     = 32'd0;
        sum_d     = hdr_sum;
        newest_d  = 8'd0;
      end
      rfc_pkg::KIND_RX: begin
        if (pending_q) begin
          if (cnt_q != 3'd0) begin
            acc_d = {acc_q[23:0], newest_q};
            sum_d = sum_q + newest_q;
          end
          newest_d = rx_byte_i;
          cnt_d    = cnt_q + 3'd1;
          finish   = ({1'b0, cnt_d} >= ({1'b0, exp_q} + 4'd1));
        end
      end
      rfc_pkg::KIND_TIMEOUT: begin
        finish = pending_q;
      end
      default: begin
      end
    endcase

    if (finish) begin
      pending_d    = 1'b0;
      frame_o.mode  = rfc_pkg::OUT_REPORT;
      frame_o.count = 3'd1;
      frame_o.bytes = '0;
      if (cnt_d == 3'd0) begin
        frame_o.status = rfc_pkg::STATUS_NO_REPLY;
      end else if (~sum_d == newest_d) begin
        frame_o.value = acc_d;
      end else begin
        frame_o.status = rfc_pkg::STATUS_BAD_SUM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      preg_q    <= 8'd0;
      exp_q     <= 3'd0;
      cnt_q     <= 3'd0;
      acc_q     <= 32'd0;
      sum_q     <= 8'd0;
      newest_q  <= 8'd0;
    end else if (fire_i) begin
      pending_q <= pending_d;
      preg_q    <= preg_d;
      exp_q     <= exp_d;
      cnt_q     <= cnt_d;
      acc_q     <= acc_d;
      sum_q     <= sum_d;
      newest_q  <= newest_d;
    end
  end

  logic unused_preg;
  assign unused_preg = ^preg_q;

endmodule

`default_nettype wire

// ===== rtl/rfc_emitter.sv =====
`default_nettype none

module rfc_emitter (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire rfc_pkg::frame_t frame_i,
  output logic                 load_ok_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 out_kind_o,
  output logic [7:0]           tx_byte_o,
  output logic                 end_of_run_o,
  output logic [31:0]          read_value_o,
  output logic [1:0]           read_status_o
);

  rfc_pkg::frame_t frame_q;
  logic [2:0]      cnt_q;
  logic [2:0]      idx_q;
  logic            take;
  logic            last;
  logic            is_report;

  assign out_valid_o = (cnt_q != 3'd0);
  assign take        = out_valid_o && out_ready_i;
  assign last        = (idx_q == (cnt_q - 3'd1));
  assign load_ok_o   = !out_valid_o || (take && last);
  assign is_report   = (frame_q.mode == rfc_pkg::OUT_REPORT);

  assign out_kind_o    = frame_q.mode;
  assign tx_byte_o     = is_report ? 8'd0 : frame_q.bytes[idx_q];
  assign end_of_run_o  = !is_report && last;
  assign read_value_o  = is_report ? frame_q.value : 32'd0;
  assign read_status_o = is_report ? frame_q.status : rfc_pkg::STATUS_OK;

  // hold the frame of the accepted beat; results advance one per output handshake
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      frame_q <= frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 3'd0;
    end else if (fire_i) begin
      cnt_q <= frame_i.count;
      idx_q <= 3'd0;
    end else if (take) begin
      if (last) begin
        cnt_q <= 3'd0;
        idx_q <= 3'd0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfc_checker.sv =====
`default_nettype none
`include "register_frame_codec_top_defines.svh"

module rfc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  kind_i,
  input wire logic [7:0]  reg_addr_i,
  input wire logic [15:0] write_data_i,
  input wire logic [2:0]  read_size_i,
  input wire logic [7:0]  rx_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        out_kind_o,
  input wire logic [7:0]  tx_byte_o,
  input wire logic        end_of_run_o,
  input wire logic [31:0] read_value_o,
  input wire logic [1:0]  read_status_o
);

  logic unused_in;
  logic out_stall;
  logic show_report;
  logic show_tx;
  logic show_error;
  logic tx_quiet;

  assign unused_in = in_valid_i ^ in_ready_o ^ (^kind_i) ^ (^reg_addr_i) ^
                     (^write_data_i) ^ (^read_size_i) ^ (^rx_byte_i);

  assign out_stall   = out_valid_o && !out_ready_i;
  assign show_report = out_valid_o && (out_kind_o == rfc_pkg::OUT_REPORT);
  assign show_tx     = out_valid_o && (out_kind_o == rfc_pkg::OUT_TX);
  assign show_error  = out_valid_o && (read_status_o != rfc_pkg::STATUS_OK);
  assign tx_quiet    = (read_status_o == rfc_pkg::STATUS_OK) && (read_value_o == 32'd0);

  `RFC_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(tx_byte_o) && $stable(out_kind_o))
  `RFC_ASSERT_IMPL(a_report_shape, show_report, !end_of_run_o && tx_byte_o == 8'd0)
  `RFC_ASSERT_IMPL(a_tx_shape, show_tx, tx_quiet)
  `RFC_ASSERT_IMPL(a_status_code, out_valid_o, read_status_o <= rfc_pkg::STATUS_BAD_SUM)
  `RFC_ASSERT_IMPL(a_err_zero, show_error, read_value_o == 32'd0)

endmodule

bind register_frame_codec_top rfc_checker u_rfc_checker (.*);

`default_nettype wire
